// ----- rtl/fpd_pkg.sv -----
// shared types, constants and helpers of the q16.16 fixed-point divider
// no dependencies; compiled before every other file of the block

package fpd_pkg;

   localparam int DATA_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [DATA_W-1:0] SIGN_MASK = 32'h8000_0000;

   // classified operand pair, as handed from the front end to the queue
   typedef struct packed {
      logic [DATA_W-1:0] mag_a;
      logic [DATA_W-1:0] mag_b;
      logic              neg;
      logic              dbz;
   } fpd_item_type;

   // unsigned magnitude of a two's complement word; the most negative value gives 2^31
   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] res;
      if ((v & SIGN_MASK) == '0) begin
         res = v;
      end else begin
         res = '0 - v;
      end
      return res;
   endfunction

endpackage

// ----- rtl/fpd_if.sv -----
// request and response channel interfaces of the fixed-point divider
// depends on fpd_pkg for the data width

interface fpd_req_if;
   import fpd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] dividend;
   logic signed [DATA_W-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface fpd_rsp_if;
   import fpd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] quotient;
   logic                     div_by_zero;

   modport source (output valid, output quotient, output div_by_zero, input ready);
   modport sink   (input valid, input quotient, input div_by_zero, output ready);
endinterface

// ----- rtl/fpd_front.sv -----
// front end: takes a request, forms operand magnitudes, result sign and zero flag
// depends on fpd_pkg and fpd_if

module fpd_front (
   input  logic                 clock,
   input  logic                 reset,
   fpd_req_if.sink              req,
   output fpd_pkg::fpd_item_type item_out,
   output logic                 item_valid,
   input  logic                 item_ready
);
   import fpd_pkg::*;

   fpd_item_type item_ff;
   fpd_item_type item_in;
   logic         valid_ff;
   logic         valid_in;
   logic         take;

   // the holding register frees up when it is empty or being drained
   assign req.ready = !valid_ff || item_ready;
   assign take      = req.valid && req.ready;

   // classify the operand pair
   always_comb begin
      item_in.mag_a = magnitude($unsigned(req.dividend));
      item_in.mag_b = magnitude($unsigned(req.divisor));
      item_in.neg   = (($unsigned(req.dividend) ^ $unsigned(req.divisor)) & SIGN_MASK) != '0;
      item_in.dbz   = (req.divisor == '0);
   end

   // valid flag follows take and drain
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_out   = item_ff;
   assign item_valid = valid_ff;

endmodule

// ----- rtl/fpd_queue.sv -----
// short request queue between the front end and the divider pipeline
// depends on fpd_pkg

module fpd_queue #(
   parameter int DEPTH = fpd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fpd_pkg::fpd_item_type in_item,
   input  logic                 in_valid,
   output logic                 in_ready,
   output fpd_pkg::fpd_item_type out_item,
   output logic                 out_valid,
   input  logic                 out_ready
);
   import fpd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   fpd_item_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count beyond depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count missed a push");

endmodule

// ----- rtl/fpd_back.sv -----
// divider pipeline: one restoring step per stage, then sign fix-up and output register
// depends on fpd_pkg and fpd_if

module fpd_back #(
   parameter int FRAC_BITS = fpd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fpd_pkg::fpd_item_type in_item,
   input  logic                 in_valid,
   output logic                 in_ready,
   fpd_rsp_if.source            rsp
);
   import fpd_pkg::*;

   localparam int STEPS = DATA_W + FRAC_BITS;

   logic [DATA_W-1:0] rem_ff [STEPS];
   logic [DATA_W-1:0] rem_in [STEPS];
   logic [STEPS-1:0]  num_ff [STEPS];
   logic [STEPS-1:0]  num_in [STEPS];
   logic [DATA_W-1:0] quo_ff [STEPS];
   logic [DATA_W-1:0] quo_in [STEPS];
   logic [DATA_W-1:0] div_ff [STEPS];
   logic [DATA_W-1:0] div_in [STEPS];
   logic [STEPS-1:0]  neg_ff;
   logic [STEPS-1:0]  neg_in;
   logic [STEPS-1:0]  dbz_ff;
   logic [STEPS-1:0]  dbz_in;
   logic [STEPS-1:0]  vld_ff;
   logic [STEPS-1:0]  vld_in;

   logic              rsp_vld_ff;
   logic [DATA_W-1:0] rsp_quo_ff;
   logic [DATA_W-1:0] rsp_quo_in;
   logic              rsp_dbz_ff;
   logic              advance;

   // whole pipeline moves unless a finished result is held up
   assign advance  = !rsp_vld_ff || rsp.ready;
   assign in_ready = advance;

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic [DATA_W-1:0] rem_src;
      logic [STEPS-1:0]  num_src;
      logic [DATA_W-1:0] quo_src;
      logic [DATA_W:0]   trial;
      logic [DATA_W:0]   diff;
      logic              fits;

      // stage source: queue head for the first stage, previous stage otherwise
      if (k == 0) begin : g_first
         always_comb begin
            rem_src   = '0;
            num_src   = {in_item.mag_a, {FRAC_BITS{1'b0}}};
            quo_src   = '0;
            div_in[k] = in_item.mag_b;
            neg_in[k] = in_item.neg;
            dbz_in[k] = in_item.dbz;
            vld_in[k] = in_valid;
         end
      end else begin : g_next
         always_comb begin
            rem_src   = rem_ff[k-1];
            num_src   = num_ff[k-1];
            quo_src   = quo_ff[k-1];
            div_in[k] = div_ff[k-1];
            neg_in[k] = neg_ff[k-1];
            dbz_in[k] = dbz_ff[k-1];
            vld_in[k] = vld_ff[k-1];
         end
      end

      // one restoring step: bring down a bit, subtract the divisor if it fits
      always_comb begin
         trial     = {rem_src, num_src[STEPS-1]};
         diff      = trial - {1'b0, div_in[k]};
         fits      = (trial >= {1'b0, div_in[k]});
         rem_in[k] = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         num_in[k] = {num_src[STEPS-2:0], 1'b0};
         quo_in[k] = {quo_src[DATA_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            quo_ff[k] <= quo_in[k];
            div_ff[k] <= div_in[k];
            neg_ff[k] <= neg_in[k];
            dbz_ff[k] <= dbz_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // sign fix-up and zero-divisor override
   always_comb begin
      rsp_quo_in = quo_ff[STEPS-1];
      if (neg_ff[STEPS-1]) begin
         rsp_quo_in = '0 - quo_ff[STEPS-1];
      end
      if (dbz_ff[STEPS-1]) begin
         rsp_quo_in = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_quo_ff <= rsp_quo_in;
         rsp_dbz_ff <= dbz_ff[STEPS-1];
      end
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.quotient    = $signed(rsp_quo_ff);
   assign rsp.div_by_zero = rsp_dbz_ff;

   // checks
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp.ready) |=> ($stable(vld_ff) && rsp_vld_ff))
      else $error("pipeline moved while the response was stalled");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_dbz_ff) |-> (rsp_quo_ff == '0))
      else $error("zero divisor gave a non-zero quotient");

endmodule

// ----- rtl/fixed_point_divide_q16_16.sv -----
// top level of the signed q16.16 fixed-point divider
// depends on fpd_pkg, fpd_if, fpd_front, fpd_queue and fpd_back

// Signed fixed-point divider: each request carries a two's complement dividend and divisor
// with FRAC_BITS fraction bits, and each response gives trunc(dividend * 2^FRAC_BITS /
// divisor) cut to its low 32 bits, so an overflowing quotient wraps. A zero divisor returns
// quotient 0 with div_by_zero set. One request is taken every clock cycle while no response
// is held back by rsp.ready; each passes through the front-end register, the queue, the
// restoring divider pipeline that performs one quotient bit per stage and the output
// register, and the front-end register loads on the accepting edge itself. A response
// held back by rsp.ready stalls the pipeline, while the front end and the queue keep
// taking up to QUEUE_DEPTH + 1 requests.

module fixed_point_divide_q16_16 #(
   parameter int FRAC_BITS   = fpd_pkg::FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = fpd_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   fpd_req_if.sink   req,
   fpd_rsp_if.source rsp
);
   import fpd_pkg::*;

   fpd_item_type front_item;
   logic         front_valid;
   logic         front_ready;
   fpd_item_type queue_item;
   logic         queue_valid;
   logic         queue_ready;

   // classify requests
   fpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .item_out   (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   // decouple front end from the divider
   fpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (front_item),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_item  (queue_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready)
   );

   // divider pipeline and response register
   fpd_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_item  (queue_item),
      .in_valid (queue_valid),
      .in_ready (queue_ready),
      .rsp      (rsp)
   );

endmodule
